### design/pra_pkg.sv
`timescale 1ns / 1ps

package pra_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MARK,
        ST_DONE
    } state_t;

    typedef logic [1:0] action_t;
    typedef logic [2:0] status_t;

    localparam action_t ACT_ALLOC = 2'd0;
    localparam action_t ACT_FREE  = 2'd1;
    localparam action_t ACT_COUNT = 2'd2;

    localparam status_t STAT_OK       = 3'd0;
    localparam status_t STAT_PRESENT  = 3'd1;
    localparam status_t STAT_NOFIT    = 3'd2;
    localparam status_t STAT_NOTFOUND = 3'd3;
    localparam status_t STAT_BAD      = 3'd4;

    localparam int OWNER_W = 8;
    localparam int COUNT_W = 6;
    localparam int FIRST_W = 5;

    localparam logic [COUNT_W-1:0] TOTAL_MAX = 6'd63;
    localparam logic [OWNER_W-1:0] OWNER_FREE = 8'd0;

endpackage

### design/pra_page_ram.sv
`timescale 1ns / 1ps

module pra_page_ram
    import pra_pkg::*;
#(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [OWNER_W-1:0] wr_data,
    input  logic [AW-1:0]      rd_addr,
    output logic [OWNER_W-1:0] rd_data
);

    // Entries never written since reset read as free.
    logic [OWNER_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [OWNER_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : OWNER_FREE;

endmodule

### design/page_run_allocator.sv
`timescale 1ns / 1ps
// A request with a bad owner, count or action skips the scan and returns a bad status.
// Other requests scan the whole owner memory through its single read port, and a granted
// allocate then marks its pages, one page per write.
// One request is in work at a time; the next is taken once the result is in the output register.
// Reset (rst_n, asynchronous, active low) frees every page at once and selects best fit.

module page_run_allocator
    import pra_pkg::*;
#(
    parameter int PAGE_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_wr_data,   // fit_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // owner[7:0], page_request[13:8], zero[15:14]
    input  logic [1:0]  s_tuser,       // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // status[2:0], first_page[7:3], page_total[13:8], zero
);

    localparam int IDX_W = $clog2(PAGE_COUNT);
    localparam int LEN_W = $clog2(PAGE_COUNT + 1);
    localparam int CMP_W = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGE_COUNT - 1);
    localparam logic [CMP_W-1:0] POOL_LEN = CMP_W'(PAGE_COUNT);

    state_t state_reg, state_next;

    logic                 fit_mode_reg;
    action_t              act_reg, act_next;
    logic [OWNER_W-1:0]   owner_reg, owner_next;
    logic [COUNT_W-1:0]   need_reg, need_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 d_vld_reg, d_vld_next;
    logic [IDX_W-1:0]     d_idx_reg, d_idx_next;
    logic [LEN_W-1:0]     cur_len_reg, cur_len_next;
    logic [IDX_W-1:0]     cur_start_reg, cur_start_next;
    logic                 present_reg, present_next;
    logic                 exact_reg, exact_next;
    logic                 have_reg, have_next;
    logic [LEN_W-1:0]     pick_len_reg, pick_len_next;
    logic [IDX_W-1:0]     pick_start_reg, pick_start_next;
    logic [COUNT_W-1:0]   tally_reg, tally_next;
    logic [IDX_W-1:0]     mark_idx_reg, mark_idx_next;
    logic [COUNT_W-1:0]   mark_left_reg, mark_left_next;
    status_t              res_status_reg, res_status_next;
    logic [FIRST_W-1:0]   res_first_reg, res_first_next;
    logic [COUNT_W-1:0]   res_total_reg, res_total_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [FIRST_W-1:0]   out_first_reg, out_first_next;
    logic [COUNT_W-1:0]   out_total_reg, out_total_next;

    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic [OWNER_W-1:0]   ram_wr_data;
    logic [IDX_W-1:0]     ram_rd_addr;
    logic [OWNER_W-1:0]   ram_rd_data;

    action_t              in_action;
    logic [OWNER_W-1:0]   in_owner;
    logic [COUNT_W-1:0]   in_need;
    logic                 in_bad;
    logic                 in_xfer;
    logic                 out_free;

    logic                 pg_free;
    logic                 run_end;
    logic [LEN_W-1:0]     end_len;
    logic [IDX_W-1:0]     end_start;
    logic [CMP_W-1:0]     end_len_c;
    logic [CMP_W-1:0]     need_c;
    logic                 better;
    logic                 pick_ok;

    assign in_action = s_tuser;
    assign in_owner  = s_tdata[7:0];
    assign in_need   = s_tdata[13:8];
    assign in_bad    = (in_action != ACT_ALLOC && in_action != ACT_FREE
                        && in_action != ACT_COUNT)
                     || (in_owner == OWNER_FREE && in_action != ACT_COUNT)
                     || (in_action == ACT_ALLOC
                         && (in_need == '0 || CMP_W'(in_need) > POOL_LEN));
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign pick_ok   = exact_reg || have_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_total_reg, out_first_reg, out_status_reg};

    pra_page_ram #(
        .DEPTH (PAGE_COUNT)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        pg_free   = (ram_rd_data == OWNER_FREE);
        run_end   = 1'b0;
        end_len   = cur_len_reg;
        end_start = cur_start_reg;
        if (pg_free && d_idx_reg == LAST_IDX)
        begin
            run_end   = 1'b1;
            end_len   = cur_len_reg + LEN_W'(1);
            end_start = (cur_len_reg == '0) ? d_idx_reg : cur_start_reg;
        end
        else if (!pg_free && cur_len_reg != '0)
        begin
            run_end = 1'b1;
        end
        end_len_c = CMP_W'(end_len);
        need_c    = CMP_W'(need_reg);
        if (!have_reg)
        begin
            better = 1'b1;
        end
        else if (!fit_mode_reg)
        begin
            better = end_len < pick_len_reg;
        end
        else
        begin
            better = end_len > pick_len_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = in_bad ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (d_vld_reg && d_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (act_reg == ACT_ALLOC && !present_reg && pick_ok)
                begin
                    state_next = ST_MARK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK:
            begin
                if (mark_left_reg == COUNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        act_next        = act_reg;
        owner_next      = owner_reg;
        need_next       = need_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        d_vld_next      = 1'b0;
        d_idx_next      = d_idx_reg;
        cur_len_next    = cur_len_reg;
        cur_start_next  = cur_start_reg;
        present_next    = present_reg;
        exact_next      = exact_reg;
        have_next       = have_reg;
        pick_len_next   = pick_len_reg;
        pick_start_next = pick_start_reg;
        tally_next      = tally_reg;
        mark_idx_next   = mark_idx_reg;
        mark_left_next  = mark_left_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_total_next  = res_total_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_first_next  = out_first_reg;
        out_total_next  = out_total_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = d_idx_reg;
        ram_wr_data     = OWNER_FREE;
        ram_rd_addr     = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    act_next        = in_action;
                    owner_next      = in_owner;
                    need_next       = in_need;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    cur_len_next    = '0;
                    present_next    = 1'b0;
                    exact_next      = 1'b0;
                    have_next       = 1'b0;
                    tally_next      = '0;
                    res_status_next = STAT_BAD;
                    res_first_next  = '0;
                    res_total_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    d_vld_next = 1'b1;
                    d_idx_next = idx_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                if (d_vld_reg)
                begin
                    if (pg_free)
                    begin
                        cur_len_next = cur_len_reg + LEN_W'(1);
                        if (cur_len_reg == '0)
                        begin
                            cur_start_next = d_idx_reg;
                        end
                    end
                    else
                    begin
                        cur_len_next = '0;
                    end
                    case (act_reg)
                        ACT_ALLOC:
                        begin
                            if (ram_rd_data == owner_reg)
                            begin
                                present_next = 1'b1;
                            end
                            if (run_end && !exact_reg)
                            begin
                                if (end_len_c == need_c)
                                begin
                                    exact_next      = 1'b1;
                                    pick_start_next = end_start;
                                end
                                else if (end_len_c > need_c && better)
                                begin
                                    have_next       = 1'b1;
                                    pick_len_next   = end_len;
                                    pick_start_next = end_start;
                                end
                            end
                        end
                        ACT_FREE:
                        begin
                            if (ram_rd_data == owner_reg)
                            begin
                                ram_wr_en = 1'b1;
                                if (tally_reg != TOTAL_MAX)
                                begin
                                    tally_next = tally_reg + COUNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            if (pg_free && cur_len_reg == '0 && tally_reg != TOTAL_MAX)
                            begin
                                tally_next = tally_reg + COUNT_W'(1);
                            end
                        end
                    endcase
                end
            end
            ST_DECIDE:
            begin
                res_first_next = '0;
                res_total_next = '0;
                case (act_reg)
                    ACT_ALLOC:
                    begin
                        if (present_reg)
                        begin
                            res_status_next = STAT_PRESENT;
                        end
                        else if (pick_ok)
                        begin
                            mark_idx_next  = pick_start_reg;
                            mark_left_next = need_reg;
                        end
                        else
                        begin
                            res_status_next = STAT_NOFIT;
                        end
                    end
                    ACT_FREE:
                    begin
                        res_status_next = (tally_reg == '0) ? STAT_NOTFOUND : STAT_OK;
                        res_total_next  = tally_reg;
                    end
                    default:
                    begin
                        res_status_next = STAT_OK;
                        res_total_next  = tally_reg;
                    end
                endcase
            end
            ST_MARK:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = mark_idx_reg;
                ram_wr_data    = owner_reg;
                mark_idx_next  = mark_idx_reg + IDX_W'(1);
                mark_left_next = mark_left_reg - COUNT_W'(1);
                if (mark_left_reg == COUNT_W'(1))
                begin
                    res_status_next = STAT_OK;
                    res_first_next  = FIRST_W'(pick_start_reg);
                    res_total_next  = need_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_first_next  = res_first_reg;
                    out_total_next  = res_total_reg;
                end
            end
            default:
            begin
                d_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fit_mode_reg   <= 1'b0;
            issue_done_reg <= 1'b0;
            d_vld_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            d_vld_reg      <= d_vld_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                fit_mode_reg <= cfg_wr_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        owner_reg      <= owner_next;
        need_reg       <= need_next;
        idx_reg        <= idx_next;
        d_idx_reg      <= d_idx_next;
        cur_len_reg    <= cur_len_next;
        cur_start_reg  <= cur_start_next;
        present_reg    <= present_next;
        exact_reg      <= exact_next;
        have_reg       <= have_next;
        pick_len_reg   <= pick_len_next;
        pick_start_reg <= pick_start_next;
        tally_reg      <= tally_next;
        mark_idx_reg   <= mark_idx_next;
        mark_left_reg  <= mark_left_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_total_reg  <= res_total_next;
        out_status_reg <= out_status_next;
        out_first_reg  <= out_first_next;
        out_total_reg  <= out_total_next;
    end

    a_mark_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MARK |-> int'(mark_idx_reg) + int'(mark_left_reg) <= PAGE_COUNT)
        else $error("page marking runs past the end of the pool");

    a_mark_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MARK |-> act_reg == ACT_ALLOC && !present_reg && pick_ok)
        else $error("pages marked without a chosen free run");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(out_valid_reg) && out_valid_reg |-> $past(state_reg) == ST_DONE)
        else $error("result loaded outside the completion state");

    a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg |-> state_reg == ST_SCAN)
        else $error("read data returned outside a scan");

    a_grant_total: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MARK && mark_left_reg == COUNT_W'(1)
        |=> res_status_reg == STAT_OK && res_total_reg == need_reg)
        else $error("granted page total differs from the request");

endmodule
